>>> rtl/core/hidset_pkg.sv
package hidset_pkg;

    // Result status codes
    localparam logic [2:0] STATUS_INSERTED = 3'd0;
    localparam logic [2:0] STATUS_PRESENT  = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_ABSENT   = 3'd3;
    localparam logic [2:0] STATUS_ZERO     = 3'd4;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // splitmix64 finalizer constants
    localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
    localparam int          MIX_SH0  = 30;
    localparam int          MIX_SH1  = 27;
    localparam int          MIX_SH2  = 31;

    localparam int OCC_W = 13;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CMP,
        ST_PUSH
    } hidset_state_t;

    typedef enum logic {
        HS_IDLE,
        HS_RUN
    } hidset_hash_state_t;

endpackage

>>> rtl/core/hidset_hash.sv
module hidset_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] hash
);

    hidset_pkg::hidset_hash_state_t state_reg, state_next;

    logic [1:0]  phase_reg;
    logic        round_reg;
    logic [63:0] x_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] hash_reg;
    logic        done_reg;

    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] acc_fin;

    // One 32x32 multiplier; the low 64 bits of a 64x64 product need three partials
    always_comb begin
        mul_const = round_reg ? hidset_pkg::MIX_MUL2 : hidset_pkg::MIX_MUL1;
        mul_a     = (phase_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
        mul_b     = (phase_reg == 2'd1) ? mul_const[63:32] : mul_const[31:0];
        acc_fin   = acc_reg + {prod_reg[31:0], 32'h0};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hidset_pkg::HS_IDLE: begin
                if (start) state_next = hidset_pkg::HS_RUN;
            end
            hidset_pkg::HS_RUN: begin
                if (phase_reg == 2'd3 && round_reg) state_next = hidset_pkg::HS_IDLE;
            end
            default: state_next = hidset_pkg::HS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hidset_pkg::HS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == hidset_pkg::HS_RUN) && (phase_reg == 2'd3)
                         && round_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hidset_pkg::HS_IDLE) begin
            if (start) begin
                x_reg     <= key ^ (key >> hidset_pkg::MIX_SH0);
                phase_reg <= 2'd0;
                round_reg <= 1'b0;
            end
        end else begin
            if (phase_reg != 2'd3) begin
                prod_reg <= 64'(mul_a) * 64'(mul_b);
            end
            case (phase_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg <= acc_fin;
                default: ;
            endcase
            phase_reg <= phase_reg + 2'd1;
            if (phase_reg == 2'd3) begin
                if (!round_reg) begin
                    x_reg     <= acc_fin ^ (acc_fin >> hidset_pkg::MIX_SH1);
                    round_reg <= 1'b1;
                end else begin
                    hash_reg <= acc_fin ^ (acc_fin >> hidset_pkg::MIX_SH2);
                end
            end
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

>>> rtl/core/hidset_mem.sv
module hidset_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [63:0]   wdata,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/hashed_id_set_linear_probe.sv
// Set of 64-bit identifiers in an open-addressed table of TABLE_SIZE slots (a
// power of two). Each key is hashed with the splitmix64 finalizer; the low hash
// bits give the home slot, and the block probes forward with wrap until it
// meets the key or an empty slot, or has probed every slot. op 0 inserts if
// absent, op 1 only looks up. status: 0 inserted, 1 already present, 2 table
// full, 3 absent, 4 key zero rejected (zero marks an empty slot). occupancy is
// the stored count after the operation, low 13 bits. After reset the block
// sweeps the table to zero, one slot a cycle, and does not take input until
// done. One item at a time: for a nonzero key the block hashes the key, reads
// the home slot, probes one slot per cycle and pushes the result, and takes
// the next transfer only after the push. The hash takes eight steps of the
// single shared 32x32 multiplier, which forms each of the two 64-bit products
// of the finalizer from three partials and a final add, and then a registered
// done flag. The READ state reads the home slot and the PUSH state pushes the
// result. A zero key skips the hash and the probe and goes to the push. A
// finished result waits in the output register while the next key is taken;
// a result side that holds off the previous result stalls the push until it
// is taken.
module hashed_id_set_linear_probe #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [12:0] m_occupancy
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    hidset_pkg::hidset_state_t state_reg, state_next;

    logic          op_reg;
    logic [63:0]   key_reg;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] probe_reg;
    logic [AW-1:0] clr_reg;
    logic [CW-1:0] count_reg;
    logic [2:0]    res_status_reg;
    logic          m_valid_reg;
    logic [2:0]    m_status_reg;
    logic [12:0]   m_occ_reg;

    logic          hash_start;
    logic          hash_done;
    logic [63:0]   hash_val;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [63:0]   mem_wdata;
    logic [63:0]   mem_rdata;

    logic          s_xfer;
    logic          key_zero;
    logic          hit;
    logic          empty;
    logic          last_probe;
    logic          full;
    logic          do_insert;
    logic          cmp_end;
    logic          push_ok;
    logic [2:0]    res_status;

    hidset_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_key),
        .done    (hash_done),
        .hash    (hash_val)
    );

    hidset_mem #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Probe decisions; read data is valid in ST_CMP for the slot in slot_reg
    always_comb begin
        s_xfer     = s_valid && s_ready;
        key_zero   = (s_key == 64'h0);
        hit        = (mem_rdata == key_reg);
        empty      = (mem_rdata == 64'h0);
        last_probe = (probe_reg == AW'(TABLE_SIZE - 1));
        full       = (count_reg >= CW'(TABLE_SIZE));
        do_insert  = (state_reg == hidset_pkg::ST_CMP) && !hit && empty
                     && (op_reg == hidset_pkg::OP_INSERT) && !full;
        cmp_end    = hit || empty || last_probe;
        push_ok    = !m_valid_reg || m_ready;

        if (hit) begin
            res_status = hidset_pkg::STATUS_PRESENT;
        end else if (op_reg == hidset_pkg::OP_LOOKUP) begin
            res_status = full ? hidset_pkg::STATUS_FULL : hidset_pkg::STATUS_ABSENT;
        end else if (do_insert) begin
            res_status = hidset_pkg::STATUS_INSERTED;
        end else begin
            res_status = hidset_pkg::STATUS_FULL;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hidset_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(TABLE_SIZE - 1)) state_next = hidset_pkg::ST_IDLE;
            end
            hidset_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = key_zero ? hidset_pkg::ST_PUSH : hidset_pkg::ST_HASH;
                end
            end
            hidset_pkg::ST_HASH: begin
                if (hash_done) state_next = hidset_pkg::ST_READ;
            end
            hidset_pkg::ST_READ: begin
                state_next = hidset_pkg::ST_CMP;
            end
            hidset_pkg::ST_CMP: begin
                if (cmp_end) state_next = hidset_pkg::ST_PUSH;
            end
            hidset_pkg::ST_PUSH: begin
                if (push_ok) state_next = hidset_pkg::ST_IDLE;
            end
            default: state_next = hidset_pkg::ST_IDLE;
        endcase
    end

    // Outputs and memory port control
    always_comb begin
        s_ready    = 1'b0;
        hash_start = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = slot_reg;
        mem_wdata  = key_reg;
        case (state_reg)
            hidset_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = 64'h0;
            end
            hidset_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                hash_start = s_valid && !key_zero;
            end
            hidset_pkg::ST_CMP: begin
                // Write the key into the empty slot, else prefetch the next slot
                mem_we   = do_insert;
                mem_addr = do_insert ? slot_reg : slot_reg + AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hidset_pkg::ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == hidset_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (do_insert) begin
                count_reg <= count_reg + CW'(1);
            end
            if (state_reg == hidset_pkg::ST_PUSH && push_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg  <= s_op;
            key_reg <= s_key;
            if (key_zero) res_status_reg <= hidset_pkg::STATUS_ZERO;
        end
        if (state_reg == hidset_pkg::ST_HASH && hash_done) begin
            slot_reg  <= hash_val[AW-1:0];
            probe_reg <= '0;
        end
        if (state_reg == hidset_pkg::ST_CMP) begin
            if (cmp_end) begin
                res_status_reg <= res_status;
            end else begin
                // Advance with wrap
                slot_reg  <= slot_reg + AW'(1);
                probe_reg <= probe_reg + AW'(1);
            end
        end
        if (state_reg == hidset_pkg::ST_PUSH && push_ok) begin
            m_status_reg <= res_status_reg;
            m_occ_reg    <= hidset_pkg::OCC_W'(count_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occ_reg;

    // The stored count never passes the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_SIZE))
        else $error("occupancy count exceeds table size");

    // A write during probing is an insert that bumps the count by one
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hidset_pkg::ST_CMP && mem_we) |=>
        (res_status_reg == hidset_pkg::STATUS_INSERTED
         && count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("insert did not record status or count");

    // A key that is found leaves the count alone
    a_hit_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hidset_pkg::ST_CMP && hit) |=>
        (count_reg == $past(count_reg) && res_status_reg == hidset_pkg::STATUS_PRESENT))
        else $error("hit changed the count or status");

    // No input transfer is taken during the clearing sweep or a probe
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hidset_pkg::ST_CLEAR || state_reg == hidset_pkg::ST_CMP) |->
        !s_ready)
        else $error("input taken while busy");

endmodule
